FILE: design/gcsw_pkg.sv
`timescale 1ns / 1ps

package gcsw_pkg;

  localparam int DIM_DEFAULT = 256;
  localparam int COORD_W = 8;
  localparam int SIZE_W = 9;
  localparam int LEN_W = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_DIRS = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GOAL_COL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GOAL_ROW = 2'd3;

  localparam logic [1:0] DIR_LEFT = 2'd0;
  localparam logic [1:0] DIR_UP = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  typedef enum logic {
    CMD_WRITE,
    CMD_QUERY
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic              free;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_SELECT,
    ST_DECIDE,
    ST_MERGE,
    ST_EMIT
  } state_t;

endpackage

FILE: design/grid_corridor_successor_walk.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        to block   in_valid/in_stall    operation, cell_col, cell_row, cell_free
// out       from block out_valid/out_stall  child_valid, child_col, child_row,
//                                           path_length, walk_capped, last_result
// cfg       to block   cfg_write            cfg_index, cfg_data
//
// an accepted write goes through the input register and the queue into the map when the
// walker is idle; a query takes the same path to the walker, then a neighbor probe, per
// corridor cell a probe (three row reads on the single map read port) and one decision,
// select steps over the directions, a merge per walk and the results, held by out_stall
// after reset the map is cleared one row a cycle, all MAX_DIM rows, with in_stall high
// the input stage and a two-entry queue take up to three items while the walker is busy

module grid_corridor_successor_walk #(
  parameter int MAX_DIM = gcsw_pkg::DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             operation,
  input  logic [gcsw_pkg::COORD_W-1:0]     cell_col,
  input  logic [gcsw_pkg::COORD_W-1:0]     cell_row,
  input  logic                             cell_free,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             child_valid,
  output logic [gcsw_pkg::COORD_W-1:0]     child_col,
  output logic [gcsw_pkg::COORD_W-1:0]     child_row,
  output logic [gcsw_pkg::LEN_W-1:0]       path_length,
  output logic                             walk_capped,
  output logic                             last_result,
  input  logic                             cfg_write,
  input  logic [gcsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcsw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gcsw_pkg::*;

  logic        clearing;
  logic        push;
  logic        pop;
  item_t       push_item;
  item_t       head;
  queue_stat_t q_stat;

  gcsw_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .cell_free (cell_free),
    .clearing  (clearing),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  gcsw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  gcsw_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .child_valid (child_valid),
    .child_col   (child_col),
    .child_row   (child_row),
    .path_length (path_length),
    .walk_capped (walk_capped),
    .last_result (last_result)
  );

endmodule

FILE: design/gcsw_front.sv
`timescale 1ns / 1ps

module gcsw_front #(
  parameter int MAX_DIM = gcsw_pkg::DIM_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [gcsw_pkg::COORD_W-1:0] cell_col,
  input  logic [gcsw_pkg::COORD_W-1:0] cell_row,
  input  logic                         cell_free,
  input  logic                         clearing,
  input  gcsw_pkg::queue_stat_t        q_stat,
  output logic                         push,
  output gcsw_pkg::item_t              push_item
);
  import gcsw_pkg::*;

  logic  held;
  item_t item;
  logic  accept;
  logic  keep;

  // out-of-range writes are dropped here
  assign keep = (operation == 1'b1) ||
                ((32'(cell_col) < MAX_DIM) && (32'(cell_row) < MAX_DIM));
  assign push = held && !q_stat.full;
  assign in_stall = clearing || (held && q_stat.full);
  assign accept = in_valid && !in_stall;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept && keep) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      item.cmd <= operation ? CMD_QUERY : CMD_WRITE;
      item.col <= cell_col;
      item.row <= cell_row;
      item.free <= cell_free;
    end
  end

endmodule

FILE: design/gcsw_queue.sv
`timescale 1ns / 1ps

module gcsw_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gcsw_pkg::item_t       push_item,
  input  logic                  pop,
  output gcsw_pkg::item_t       head,
  output gcsw_pkg::queue_stat_t q_stat
);
  import gcsw_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_stat.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: design/gcsw_back.sv
`timescale 1ns / 1ps

module gcsw_back #(
  parameter int MAX_DIM = gcsw_pkg::DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gcsw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcsw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  gcsw_pkg::item_t                  head,
  input  gcsw_pkg::queue_stat_t            q_stat,
  output logic                             pop,
  output logic                             clearing,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             child_valid,
  output logic [gcsw_pkg::COORD_W-1:0]     child_col,
  output logic [gcsw_pkg::COORD_W-1:0]     child_row,
  output logic [gcsw_pkg::LEN_W-1:0]       path_length,
  output logic                             walk_capped,
  output logic                             last_result
);
  import gcsw_pkg::*;

  localparam int AW = $clog2(MAX_DIM);
  localparam int LIM = (MAX_DIM < 256) ? MAX_DIM : 256;
  localparam logic [SIZE_W-1:0] LIM_W = SIZE_W'(LIM);

  // map: one row per word, 1 = free
  logic [MAX_DIM-1:0] map_mem [MAX_DIM];
  logic [MAX_DIM-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      clr_row;
  logic               wr_en;

  logic [SIZE_W-1:0]  grid_width, grid_height;
  logic [COORD_W-1:0] goal_col, goal_row;
  logic [SIZE_W-1:0]  eff_w, eff_h;
  logic [LEN_W-1:0]   cap;

  state_t             state, state_next;
  logic [1:0]         ph, ph_next;
  logic               walking, walking_next;
  logic [COORD_W-1:0] c, c_next, r, r_next;
  logic [COORD_W-1:0] qcol, qcol_next, qrow, qrow_next;
  logic [1:0]         dir, dir_next;
  logic [2:0]         k, k_next;
  logic [LEN_W-1:0]   d, d_next;
  logic               capped, capped_next;
  logic [3:0]         nb, nb_next, qnb, qnb_next;
  logic [2:0]         n, n_next;
  logic [1:0]         e, e_next;
  logic [COORD_W-1:0] ec [NUM_DIRS], ec_next [NUM_DIRS];
  logic [COORD_W-1:0] er [NUM_DIRS], er_next [NUM_DIRS];
  logic [LEN_W-1:0]   elen [NUM_DIRS], elen_next [NUM_DIRS];
  logic               ecap [NUM_DIRS], ecap_next [NUM_DIRS];

  logic               out_valid_next;
  logic               ocv_next, ocap_next, olast_next;
  logic [COORD_W-1:0] ocol_next, orow_next;
  logic [LEN_W-1:0]   olen_next;

  logic               col_ok, left_ok, right_ok, up_ok, mid_ok, down_ok;
  logic [3:0]         cand;
  logic               one_way, at_goal, cont;
  logic [1:0]         found;
  logic [NUM_DIRS-1:0] match;

  assign clearing = (state == ST_CLEAR);

  assign col_ok = {1'b0, c} < eff_w;
  assign left_ok = (c != '0) && (({1'b0, c} - 1'b1) < eff_w);
  assign right_ok = ({1'b0, c} + 1'b1) < eff_w;
  assign up_ok = (r != '0) && (({1'b0, r} - 1'b1) < eff_h);
  assign mid_ok = {1'b0, r} < eff_h;
  assign down_ok = ({1'b0, r} + 1'b1) < eff_h;

  assign cand = nb & ~(4'b0001 << (dir ^ 2'd2));
  assign one_way = (cand != '0) && ((cand & (cand - 1'b1)) == '0);
  assign at_goal = (c == goal_col) && (r == goal_row);
  assign cont = one_way && !at_goal;

  always_comb begin
    priority if (cand[DIR_LEFT]) begin
      found = DIR_LEFT;
    end else if (cand[DIR_UP]) begin
      found = DIR_UP;
    end else if (cand[DIR_RIGHT]) begin
      found = DIR_RIGHT;
    end else begin
      found = DIR_DOWN;
    end
  end

  always_comb begin
    for (int m = 0; m < NUM_DIRS; m++) begin
      match[m] = (3'(m) < n) && (ec[m] == c) && (er[m] == r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 9'd256;
      grid_height <= 9'd256;
      goal_col <= '0;
      goal_row <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_GOAL_COL:    goal_col <= cfg_data[COORD_W-1:0];
        CFG_GOAL_ROW:    goal_row <= cfg_data[COORD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    eff_w <= (grid_width > LIM_W) ? LIM_W : grid_width;
    eff_h <= (grid_height > LIM_W) ? LIM_W : grid_height;
    cap <= {8'd0, eff_w} * {8'd0, eff_h};
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      map_mem[clr_row] <= '0;
    end else if (wr_en) begin
      map_mem[AW'(head.row)][AW'(head.col)] <= head.free;
    end
    rd_data <= map_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    ph_next = ph;
    walking_next = walking;
    c_next = c;
    r_next = r;
    qcol_next = qcol;
    qrow_next = qrow;
    dir_next = dir;
    k_next = k;
    d_next = d;
    capped_next = capped;
    nb_next = nb;
    qnb_next = qnb;
    n_next = n;
    e_next = e;
    ec_next = ec;
    er_next = er;
    elen_next = elen;
    ecap_next = ecap;
    out_valid_next = out_valid && out_stall;
    ocv_next = child_valid;
    ocol_next = child_col;
    orow_next = child_row;
    olen_next = path_length;
    ocap_next = walk_capped;
    olast_next = last_result;
    pop = 1'b0;
    wr_en = 1'b0;
    rd_addr = AW'(r);

    unique case (state)
      ST_CLEAR: begin
        if (clr_row == AW'(MAX_DIM - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (head.cmd == CMD_WRITE) begin
            wr_en = 1'b1;
          end else begin
            qcol_next = head.col;
            qrow_next = head.row;
            c_next = head.col;
            r_next = head.row;
            walking_next = 1'b0;
            k_next = '0;
            n_next = '0;
            ph_next = '0;
            state_next = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        ph_next = ph + 1'b1;
        unique case (ph)
          2'd0: begin
            rd_addr = AW'(r - 1'b1);
          end
          2'd1: begin
            nb_next[DIR_UP] = up_ok && col_ok && rd_data[AW'(c)];
            rd_addr = AW'(r);
          end
          2'd2: begin
            nb_next[DIR_LEFT] = left_ok && mid_ok && rd_data[AW'(c - 1'b1)];
            nb_next[DIR_RIGHT] = right_ok && mid_ok && rd_data[AW'(c + 1'b1)];
            rd_addr = AW'(r + 1'b1);
          end
          2'd3: begin
            nb_next[DIR_DOWN] = down_ok && col_ok && rd_data[AW'(c)];
            if (walking) begin
              state_next = ST_DECIDE;
            end else begin
              qnb_next = nb_next;
              state_next = ST_SELECT;
            end
          end
        endcase
      end
      ST_SELECT: begin
        if (k[2]) begin
          e_next = '0;
          state_next = ST_EMIT;
        end else if (qnb[k[1:0]]) begin
          unique case (k[1:0])
            DIR_LEFT: begin
              c_next = qcol - 1'b1;
              r_next = qrow;
            end
            DIR_UP: begin
              c_next = qcol;
              r_next = qrow - 1'b1;
            end
            DIR_RIGHT: begin
              c_next = qcol + 1'b1;
              r_next = qrow;
            end
            DIR_DOWN: begin
              c_next = qcol;
              r_next = qrow + 1'b1;
            end
          endcase
          dir_next = k[1:0];
          d_next = LEN_W'(1);
          capped_next = 1'b0;
          walking_next = 1'b1;
          ph_next = '0;
          state_next = ST_PROBE;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (cont && (d >= cap)) begin
          capped_next = 1'b1;
          state_next = ST_MERGE;
        end else if (cont) begin
          d_next = d + 1'b1;
          dir_next = found;
          unique case (found)
            DIR_LEFT:  c_next = c - 1'b1;
            DIR_UP:    r_next = r - 1'b1;
            DIR_RIGHT: c_next = c + 1'b1;
            DIR_DOWN:  r_next = r + 1'b1;
          endcase
          ph_next = '0;
          state_next = ST_PROBE;
        end else begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (match != '0) begin
          for (int m = 0; m < NUM_DIRS; m++) begin
            if (match[m] && (d < elen[m])) begin
              elen_next[m] = d;
              ecap_next[m] = capped;
            end
          end
        end else begin
          ec_next[n[1:0]] = c;
          er_next[n[1:0]] = r;
          elen_next[n[1:0]] = d;
          ecap_next[n[1:0]] = capped;
          n_next = n + 1'b1;
        end
        k_next = k + 1'b1;
        walking_next = 1'b0;
        state_next = ST_SELECT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          if (n == '0) begin
            ocv_next = 1'b0;
            ocol_next = '0;
            orow_next = '0;
            olen_next = '0;
            ocap_next = 1'b0;
            olast_next = 1'b1;
            state_next = ST_IDLE;
          end else begin
            ocv_next = 1'b1;
            ocol_next = ec[e];
            orow_next = er[e];
            olen_next = elen[e];
            ocap_next = ecap[e];
            olast_next = ((3'(e) + 3'd1) == n);
            e_next = e + 1'b1;
            if ((3'(e) + 3'd1) == n) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_row <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ph <= ph_next;
    walking <= walking_next;
    c <= c_next;
    r <= r_next;
    qcol <= qcol_next;
    qrow <= qrow_next;
    dir <= dir_next;
    k <= k_next;
    d <= d_next;
    capped <= capped_next;
    nb <= nb_next;
    qnb <= qnb_next;
    n <= n_next;
    e <= e_next;
    ec <= ec_next;
    er <= er_next;
    elen <= elen_next;
    ecap <= ecap_next;
    child_valid <= ocv_next;
    child_col <= ocol_next;
    child_row <= orow_next;
    path_length <= olen_next;
    walk_capped <= ocap_next;
    last_result <= olast_next;
  end

endmodule

FILE: bench/tb_grid_corridor_successor_walk.sv
`timescale 1ns / 1ps

module tb_grid_corridor_successor_walk;
  import gcsw_pkg::*;

  localparam int MAP_DIM = DIM_DEFAULT;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 100000;
  localparam int NUM_DIRECTED = 29;
  localparam int NUM_PHASES = 7;

  // indexed by DIR_LEFT, DIR_UP, DIR_RIGHT, DIR_DOWN
  localparam int COL_STEP [4] = '{-1, 0, 1, 0};
  localparam int ROW_STEP [4] = '{0, -1, 0, 1};

  localparam int SEND_IDLE [4] = '{0, 47, 0, 25};
  localparam int RECV_STALL [4] = '{0, 0, 47, 25};

  typedef struct packed {
    logic              child_valid;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [LEN_W-1:0]  len;
    logic              capped;
    logic              last;
  } successor_t;

  localparam successor_t NO_SUCCESSOR = '{1'b0, 8'd0, 8'd0, 17'd0, 1'b0, 1'b1};

  typedef struct packed {
    logic                   is_cfg;
    cmd_t                   op;
    logic [COORD_W-1:0]     col;
    logic [COORD_W-1:0]     row;
    logic                   free;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_value;
    logic                   typed;
  } step_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic [COORD_W-1:0] cell_col = '0;
  logic [COORD_W-1:0] cell_row = '0;
  logic cell_free = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic child_valid;
  logic [COORD_W-1:0] child_col;
  logic [COORD_W-1:0] child_row;
  logic [LEN_W-1:0] path_length;
  logic walk_capped;
  logic last_result;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit [MAP_DIM-1:0] maze_rows [MAP_DIM];
  int unsigned grid_cols = 256;
  int unsigned grid_rows = 256;
  int goal_c = 0;
  int goal_r = 0;

  successor_t pending_successors [$];
  successor_t head;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // map writes, corridor to the goal, junction, merged end cells, loop corridor,
  // out-of-grid neighbor, zero size and a one-cell grid
  step_t directed_steps [NUM_DIRECTED] = '{
    '{1'b0, CMD_QUERY, 8'd0,   8'd0,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b1},
    '{1'b0, CMD_QUERY, 8'd255, 8'd255, 1'b1, CFG_GRID_WIDTH,  9'd0,   1'b1},
    '{1'b0, CMD_WRITE, 8'd255, 8'd255, 1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd254, 8'd255, 1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_QUERY, 8'd255, 8'd254, 1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd0,   8'd0,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd0,   8'd1,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd0,   8'd2,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_QUERY, 8'd0,   8'd3,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd1,   8'd0,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_QUERY, 8'd1,   8'd1,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd9,   8'd8,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd10,  8'd8,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd11,  8'd8,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd10,  8'd9,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_QUERY, 8'd9,   8'd9,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b1, CMD_WRITE, 8'd0,   8'd0,   1'b0, CFG_GRID_WIDTH,  9'd4,   1'b0},
    '{1'b1, CMD_WRITE, 8'd0,   8'd0,   1'b0, CFG_GRID_HEIGHT, 9'd4,   1'b0},
    '{1'b1, CMD_WRITE, 8'd0,   8'd0,   1'b0, CFG_GOAL_COL,    9'd3,   1'b0},
    '{1'b1, CMD_WRITE, 8'd0,   8'd0,   1'b0, CFG_GOAL_ROW,    9'd3,   1'b0},
    '{1'b0, CMD_WRITE, 8'd1,   8'd1,   1'b1, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_WRITE, 8'd0,   8'd2,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_QUERY, 8'd0,   8'd0,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_QUERY, 8'd255, 8'd254, 1'b0, CFG_GRID_WIDTH,  9'd0,   1'b1},
    '{1'b1, CMD_WRITE, 8'd0,   8'd0,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0},
    '{1'b0, CMD_QUERY, 8'd1,   8'd0,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b1},
    '{1'b1, CMD_WRITE, 8'd0,   8'd0,   1'b0, CFG_GRID_WIDTH,  9'd1,   1'b0},
    '{1'b1, CMD_WRITE, 8'd0,   8'd0,   1'b0, CFG_GRID_HEIGHT, 9'd1,   1'b0},
    '{1'b0, CMD_QUERY, 8'd1,   8'd0,   1'b0, CFG_GRID_WIDTH,  9'd0,   1'b0}
  };

  grid_corridor_successor_walk u_top (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .operation,
    .cell_col,
    .cell_row,
    .cell_free,
    .out_valid,
    .out_stall,
    .child_valid,
    .child_col,
    .child_row,
    .path_length,
    .walk_capped,
    .last_result,
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic int unsigned eff_size(int unsigned v);
    if (v > MAP_DIM) v = MAP_DIM;
    if (v > 256) v = 256;
    return v;
  endfunction

  function automatic bit cell_open(int c, int r);
    if (c < 0 || r < 0) return 1'b0;
    if (c >= eff_size(grid_cols) || r >= eff_size(grid_rows)) return 1'b0;
    return maze_rows[r][c];
  endfunction

  function automatic void queue_expected(successor_t res);
    pending_successors = {pending_successors, res};
  endfunction

  function automatic void predict_successors(logic [COORD_W-1:0] qc, logic [COORD_W-1:0] qr);
    int end_col [4];
    int end_row [4];
    int unsigned end_len [4];
    bit end_cap [4];
    int found;
    int c;
    int r;
    int dir;
    int back;
    int onward;
    int count;
    int unsigned steps;
    int unsigned limit;
    bit capped;
    bit dup;
    successor_t res;
    found = 0;
    limit = eff_size(grid_cols) * eff_size(grid_rows);
    for (int k = 0; k < 4; k++) begin
      c = int'(qc) + COL_STEP[k];
      r = int'(qr) + ROW_STEP[k];
      if (!cell_open(c, r)) continue;
      dir = k;
      steps = 1;
      capped = 1'b0;
      forever begin
        back = (dir + 2) % 4;
        count = 0;
        onward = 0;
        for (int j = 0; j < 4; j++) begin
          if (j != back && cell_open(c + COL_STEP[j], r + ROW_STEP[j])) begin
            if (count == 0) onward = j;
            count++;
          end
        end
        if (count != 1) break;
        dir = onward;
        if (c == goal_c && r == goal_r) break;
        if (steps >= limit) begin
          capped = 1'b1;
          break;
        end
        steps++;
        c += COL_STEP[dir];
        r += ROW_STEP[dir];
      end
      dup = 1'b0;
      for (int m = 0; m < found; m++) begin
        if (end_col[m] == c && end_row[m] == r) begin
          dup = 1'b1;
          if (steps < end_len[m]) begin
            end_len[m] = steps;
            end_cap[m] = capped;
          end
        end
      end
      if (!dup) begin
        end_col[found] = c;
        end_row[found] = r;
        end_len[found] = steps;
        end_cap[found] = capped;
        found++;
      end
    end
    if (found == 0) queue_expected(NO_SUCCESSOR);
    for (int m = 0; m < found; m++) begin
      res.child_valid = 1'b1;
      res.col = COORD_W'(end_col[m]);
      res.row = COORD_W'(end_row[m]);
      res.len = LEN_W'(end_len[m]);
      res.capped = end_cap[m];
      res.last = (m == found - 1);
      queue_expected(res);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_successors.size() == 0) begin
          $error("unexpected result: col %0d row %0d length %0d", child_col, child_row,
                 path_length);
          mismatch_count++;
        end else begin
          head = pending_successors.pop_front();
          check_field("child_valid", 32'(head.child_valid), 32'(child_valid));
          check_field("child_col", 32'(head.col), 32'(child_col));
          check_field("child_row", 32'(head.row), 32'(child_row));
          check_field("path_length", 32'(head.len), 32'(path_length));
          check_field("walk_capped", 32'(head.capped), 32'(walk_capped));
          check_field("last_result", 32'(head.last), 32'(last_result));
        end
      end
    end
  end

  task automatic send_item(input cmd_t op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic free, input bit typed);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    cell_col <= col;
    cell_row <= row;
    cell_free <= free;
    do @(posedge clk); while (in_stall);
    if (op == CMD_WRITE) begin
      maze_rows[row][col] = free;
    end else if (typed) begin
      queue_expected(NO_SUCCESSOR);
    end else begin
      predict_successors(col, row);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_successors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_GRID_WIDTH: grid_cols = 32'(value);
      CFG_GRID_HEIGHT: grid_rows = 32'(value);
      CFG_GOAL_COL: goal_c = int'(value[COORD_W-1:0]);
      CFG_GOAL_ROW: goal_r = int'(value[COORD_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // far_corner keeps the maze in the bottom-right corner with walls on odd rows,
  // so corridors stay short and loop-free on the full-size grid
  task automatic run_phase(input int unsigned cols, input int unsigned rows,
                           input int unsigned gcol, input int unsigned grow,
                           input int mode, input bit far_corner, input int count);
    cmd_t op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic free;
    int roll;
    int write_share;
    set_register(CFG_GRID_WIDTH, CFG_DATA_W'(cols));
    set_register(CFG_GRID_HEIGHT, CFG_DATA_W'(rows));
    set_register(CFG_GOAL_COL, CFG_DATA_W'(gcol));
    set_register(CFG_GOAL_ROW, CFG_DATA_W'(grow));
    send_idle_pct = SEND_IDLE[mode];
    recv_stall_pct = RECV_STALL[mode];
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      write_share = (i < count / 2) ? 65 : 35;
      free = 1'($urandom_range(0, 1));
      if (roll < 8) begin
        op = cmd_t'($urandom_range(0, 1));
        col = COORD_W'($urandom);
        row = far_corner ? COORD_W'($urandom_range(128, 255)) : COORD_W'($urandom);
        if (op == CMD_WRITE) free = 1'b0;
      end else if (roll < write_share) begin
        op = CMD_WRITE;
        if (far_corner) begin
          col = COORD_W'($urandom_range(236, 255));
          row = COORD_W'(236 + 2 * $urandom_range(0, 8));
          free = ($urandom_range(0, 99) < 70);
        end else begin
          col = COORD_W'($urandom_range(0, cols + 1));
          row = COORD_W'($urandom_range(0, rows + 1));
          free = ($urandom_range(0, 99) < 60);
        end
      end else begin
        op = CMD_QUERY;
        if (far_corner) begin
          col = COORD_W'($urandom_range(235, 255));
          row = COORD_W'($urandom_range(235, 255));
        end else begin
          col = COORD_W'($urandom_range(0, cols + 1));
          row = COORD_W'($urandom_range(0, rows + 1));
        end
      end
      send_item(op, col, row, free, 1'b0);
    end
  endtask

  initial begin
    int unsigned cols;
    int unsigned rows;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_steps[i].is_cfg) begin
        set_register(directed_steps[i].reg_index, directed_steps[i].reg_value);
      end else begin
        send_item(directed_steps[i].op, directed_steps[i].col, directed_steps[i].row,
                  directed_steps[i].free, directed_steps[i].typed);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 5) begin
        run_phase(511, 256, 255, 236 + 2 * $urandom_range(0, 8), p % 4, 1'b1, 30);
      end else begin
        cols = (p == 0) ? 16 : $urandom_range(1, 16);
        rows = (p == 0) ? 16 : $urandom_range(2, 16);
        run_phase(cols, rows, $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                  p % 4, 1'b0, 36);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
